// ----- rtl/ktr_pkg.sv -----
// shared types and constants for the keyed top-k ranking table
`timescale 1ns / 1ps
`default_nettype none
package ktr_pkg;
  localparam int TOP_ENTRIES = 10;
  localparam int LIST_COUNT  = 16;
  localparam int DEPTH       = TOP_ENTRIES * LIST_COUNT;
  localparam int AW          = $clog2(DEPTH);
  localparam int PW          = $clog2(TOP_ENTRIES + 1);
  localparam int SW          = $clog2(LIST_COUNT);

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BADRANK = 2'd1,
    ST_NOKEY   = 2'd2
  } status_t;

  // packed entry as held in the store
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] score;
    logic [8:0]  sect;
    logic [7:0]  gender;
    logic [7:0]  kind;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_PLACE, S_READ, S_OUT
  } state_t;

  // control from sequencer to store
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
  } mem_ctl_t;

  // signed score compare: a less than b
  function automatic logic score_less(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction
endpackage
`default_nettype wire

// ----- rtl/ktr_store.sv -----
// entry memory with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ktr_store (
  input  wire logic              clk,
  input  wire ktr_pkg::mem_ctl_t ctl,
  input  wire ktr_pkg::entry_t   wdata,
  output ktr_pkg::entry_t        rdata
);
  import ktr_pkg::*;
  entry_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (ctl.we) mem[ctl.waddr] <= wdata;
    rdata <= mem[ctl.raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/keyed_top_k_ranking_table_unit.sv -----
// top level: sequencer for upsert, clear and query over the entry store
//
// usage: drive the in_ fields and raise start while busy is low; the
// transaction is taken on that edge and busy rises. exactly one result
// appears on the out_ ports for one cycle with out_valid high; the receiver
// cannot stall it, and busy stays high through the result cycle.
// clear, unused code, key-0 upsert and queries that hit no entry go
// straight to the result; a query that hits first reads its entry.
// an upsert with n stored entries scans them one a cycle through the
// registered read port, then moves m entries by one place, m at most n,
// then writes the item. the 64-bit compare is shared and the store has
// one read port.
// reset clears all fill counts so every list starts empty; the store itself
// is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module keyed_top_k_ranking_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [3:0]  in_list_slot,
  input  wire logic [63:0] in_entry_key,
  input  wire logic [63:0] in_score,
  input  wire logic [8:0]  in_sect_code,
  input  wire logic [7:0]  in_gender_code,
  input  wire logic [7:0]  in_kind_code,
  input  wire logic [3:0]  in_rank_asked,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [63:0]      out_found_key,
  output logic [63:0]      out_found_score,
  output logic [8:0]       out_found_sect,
  output logic [7:0]       out_found_gender
);
  import ktr_pkg::*;

  state_t state_r, state_nxt;
  logic [PW-1:0] fill_r [LIST_COUNT];
  entry_t item_r;
  logic [SW-1:0] slot_r;
  logic [AW-1:0] base_r;
  logic [PW-1:0] n_r, rd_r, chk_r, dst_r, match_r, pos_r, mv_r;
  logic found_r, rdv_r, up_r;
  mem_ctl_t ctl;
  entry_t rdata, wdata;
  logic [SW-1:0] in_slot;
  logic slot_ok, rank_ok, upsert_go, query_go;
  logic key_eq, score_above, scan_done;
  logic [PW-1:0] src;
  status_t acc_status;

  ktr_store u_store (.clk(clk), .ctl(ctl), .wdata(wdata), .rdata(rdata));

  // store base address of a slot
  function automatic logic [AW-1:0] base_of(logic [SW-1:0] s);
    return AW'(int'(s) * TOP_ENTRIES);
  endfunction

  // decode of the offered transaction
  assign in_slot   = in_list_slot[SW-1:0];
  assign slot_ok   = 32'(in_list_slot) < LIST_COUNT;
  assign rank_ok   = in_rank_asked != 4'd0 && 32'(in_rank_asked) <= TOP_ENTRIES;
  assign upsert_go = in_operation == OP_UPSERT && in_entry_key != 64'd0 && slot_ok;
  assign query_go  = in_operation == OP_QUERY && rank_ok && slot_ok &&
                     PW'(in_rank_asked) <= fill_r[in_slot];

  always_comb begin
    acc_status = ST_DONE;
    if (in_operation == OP_UPSERT && in_entry_key == 64'd0)
      acc_status = ST_NOKEY;
    else if (in_operation == OP_QUERY && !rank_ok)
      acc_status = ST_BADRANK;
  end

  // shared compare: before a key match ties stay above, after it they fall below
  assign key_eq      = rdata.key == item_r.key;
  assign score_above = found_r ? score_less(item_r.score, rdata.score)
                               : !score_less(rdata.score, item_r.score);
  assign scan_done   = rd_r == n_r && !rdv_r;
  assign src         = found_r ? match_r : n_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) begin
        if (upsert_go) state_nxt = S_SCAN;
        else if (query_go) state_nxt = S_READ;
        else state_nxt = S_OUT;
      end
      S_SCAN: if (scan_done) state_nxt = S_SHIFT;
      S_SHIFT: if (mv_r == '0) state_nxt = S_PLACE;
      S_PLACE: state_nxt = S_OUT;
      S_READ: if (rdv_r) state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // store control: reads at rd_r, moved entries go to dst_r, item to pos_r
  always_comb begin
    ctl = '0;
    wdata = rdata;
    case (state_r)
      S_SCAN, S_READ: ctl.raddr = base_r + AW'(rd_r);
      S_SHIFT: begin
        ctl.raddr = base_r + AW'(rd_r);
        ctl.we = rdv_r && 32'(dst_r) < TOP_ENTRIES;
        ctl.waddr = base_r + AW'(dst_r);
      end
      S_PLACE: begin
        ctl.we = 32'(pos_r) < TOP_ENTRIES;
        ctl.waddr = base_r + AW'(pos_r);
        wdata = item_r;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int k = 0; k < LIST_COUNT; k++) fill_r[k] <= '0;
      rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (start) begin
          item_r <= '{in_entry_key, in_score, in_sect_code, in_gender_code,
                      in_kind_code};
          slot_r <= in_slot;
          base_r <= base_of(in_slot);
          n_r <= slot_ok ? fill_r[in_slot] : '0;
          rd_r <= query_go ? PW'(in_rank_asked - 4'd1) : '0;
          found_r <= 1'b0;
          match_r <= '0;
          pos_r <= '0;
          rdv_r <= 1'b0;
          if (in_operation == OP_CLEAR && slot_ok) fill_r[in_slot] <= '0;
        end
        S_SCAN: begin
          // set up the move once every entry has been compared
          if (scan_done) begin
            up_r <= pos_r > src;
            mv_r <= pos_r > src ? pos_r - src : src - pos_r;
            rd_r <= pos_r > src ? src + PW'(1) : src - PW'(1);
          end else if (rd_r != n_r) begin
            rd_r <= rd_r + PW'(1);
            chk_r <= rd_r;
          end
          rdv_r <= rd_r != n_r;
          // compare the entry read last cycle
          if (rdv_r) begin
            if (!found_r && key_eq) begin
              found_r <= 1'b1;
              match_r <= chk_r;
            end else if (score_above) begin
              pos_r <= pos_r + PW'(1);
            end
          end
        end
        S_SHIFT: begin
          // read one ahead, write each entry one place over
          rdv_r <= mv_r != '0;
          if (mv_r != '0) begin
            mv_r <= mv_r - PW'(1);
            rd_r <= up_r ? rd_r + PW'(1) : rd_r - PW'(1);
            dst_r <= up_r ? rd_r - PW'(1) : rd_r + PW'(1);
          end
        end
        S_PLACE: begin
          if (!found_r && 32'(n_r) < TOP_ENTRIES)
            fill_r[slot_r] <= n_r + PW'(1);
        end
        S_READ: rdv_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // result strobe during the output state
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= state_nxt == S_OUT;
  end

  // result fields: empty pattern at accept, entry on a query hit
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      out_status <= acc_status;
      out_found_key <= 64'd0;
      out_found_score <= 64'd0;
      out_found_sect <= 9'h1FF;
      out_found_gender <= 8'd0;
    end else if (state_r == S_READ && rdv_r) begin
      out_found_key <= rdata.key;
      out_found_score <= rdata.score;
      out_found_sect <= rdata.sect;
      out_found_gender <= rdata.gender;
    end
  end

  assign busy = state_r != S_IDLE;

  // checks
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == (state_r == S_OUT)) else $error("result strobe out of step");
  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> busy) else $error("not busy while working");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held too long");
endmodule
`default_nettype wire
